[rtl/core/dpod_pkg.sv]
// ============================================================================
// dpod_pkg: shared types and constants for the date period overlap block
// Field widths, the day serial width, the month offset table and the
// reciprocal used to divide years by one hundred.
// ============================================================================
`default_nettype none

package dpod_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int SERIAL_W = 23;
    localparam int COUNT_W  = 22;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 43699
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 13;

    localparam int DAYS_PER_YEAR = 365;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

    typedef logic [DAY_W-1:0]    day_t;
    typedef logic [MONTH_W-1:0]  month_t;
    typedef logic [YEAR_W-1:0]   year_t;
    typedef logic [SERIAL_W-1:0] serial_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // Days before the first of the month; out of range months clamp.
    function automatic logic [8:0] month_base(input month_t month);
        logic [8:0] base;
        case (month)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            default: base = 9'd334;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

[rtl/core/dpod_serial.sv]
// ============================================================================
// dpod_serial: Gregorian date to day serial number
// Counts the days of years 0 .. year-1, adds the month offset, the leap day
// when past February, and the day of month.
// ============================================================================
`default_nettype none

module dpod_serial (
    input  wire dpod_pkg::day_t    day,
    input  wire dpod_pkg::month_t  month,
    input  wire dpod_pkg::year_t   year,
    output dpod_pkg::serial_t      serial
);
    import dpod_pkg::*;

    localparam int PROD_W = YEAR_W + 1 + RECIP_W;

    logic [YEAR_W:0]     year_p3;
    logic [YEAR_W:0]     year_p99;
    logic [YEAR_W:0]     year_p399;
    logic [PROD_W-1:0]   prod_99;
    logic [PROD_W-1:0]   prod_399;
    logic [PROD_W-1:0]   prod_yr;
    logic [7:0]          ceil_100;
    logic [5:0]          ceil_400;
    logic [7:0]          quot_100;
    logic                div_100;
    logic                leap;
    serial_t             year_days;

    always_comb
    begin
        year_p3   = {1'b0, year} + (YEAR_W+1)'(3);
        year_p99  = {1'b0, year} + (YEAR_W+1)'(99);
        year_p399 = {1'b0, year} + (YEAR_W+1)'(399);

        prod_99  = PROD_W'(year_p99) * PROD_W'(RECIP_100);
        prod_399 = PROD_W'(year_p399[YEAR_W:2]) * PROD_W'(RECIP_100);
        prod_yr  = PROD_W'(year) * PROD_W'(RECIP_100);

        ceil_100 = prod_99[RECIP_SHIFT +: 8];
        ceil_400 = prod_399[RECIP_SHIFT +: 6];
        quot_100 = prod_yr[RECIP_SHIFT +: 8];

        div_100 = (year == YEAR_W'(quot_100) * YEAR_W'(100));
        leap    = (year[1:0] == 2'b00) && (!div_100 || (quot_100[1:0] == 2'b00));

        year_days = SERIAL_W'(year) * SERIAL_W'(DAYS_PER_YEAR)
                  + SERIAL_W'(year_p3[YEAR_W:2])
                  - SERIAL_W'(ceil_100)
                  + SERIAL_W'(ceil_400);

        serial = year_days
               + SERIAL_W'(month_base(month))
               + SERIAL_W'(leap && (month > MONTH_FEB))
               + SERIAL_W'(day);
    end

endmodule

`default_nettype wire

[rtl/core/date_period_overlap_days.sv]
// ============================================================================
// date_period_overlap_days: inclusive overlap of two date periods
// Converts four dates to day serials and counts the shared days.
// ============================================================================
// Each transfer carries two periods (start and end dates); one transfer of
// overlap_days follows for each, the count of days in both periods with end
// dates included, zero when the periods are disjoint or either one is
// reversed, saturated at the top of the 22-bit range. The block is a
// two-stage pipeline (date serials, then compare and subtract): it takes a
// new transfer every cycle unless the output is stalled, and each result
// passes through the serial registers and then the count register.
`default_nettype none

module date_period_overlap_days (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire dpod_pkg::day_t    first_start_day,
    input  wire dpod_pkg::month_t  first_start_month,
    input  wire dpod_pkg::year_t   first_start_year,
    input  wire dpod_pkg::day_t    first_end_day,
    input  wire dpod_pkg::month_t  first_end_month,
    input  wire dpod_pkg::year_t   first_end_year,
    input  wire dpod_pkg::day_t    second_start_day,
    input  wire dpod_pkg::month_t  second_start_month,
    input  wire dpod_pkg::year_t   second_start_year,
    input  wire dpod_pkg::day_t    second_end_day,
    input  wire dpod_pkg::month_t  second_end_month,
    input  wire dpod_pkg::year_t   second_end_year,
    output logic                   out_valid,
    input  wire                    out_stall,
    output dpod_pkg::count_t       overlap_days
);
    import dpod_pkg::*;

    serial_t s1_ser;
    serial_t e1_ser;
    serial_t s2_ser;
    serial_t e2_ser;

    serial_t s1_reg;
    serial_t e1_reg;
    serial_t s2_reg;
    serial_t e2_reg;
    logic    stage_valid_reg;
    logic    stage_valid_next;

    logic    out_valid_reg;
    logic    out_valid_next;
    count_t  count_reg;
    count_t  count_next;

    logic    out_load;
    logic    stage_load;

    serial_t             lo;
    serial_t             hi;
    logic [SERIAL_W:0]   span;

    dpod_serial u_first_start (
        .day    (first_start_day),
        .month  (first_start_month),
        .year   (first_start_year),
        .serial (s1_ser)
    );

    dpod_serial u_first_end (
        .day    (first_end_day),
        .month  (first_end_month),
        .year   (first_end_year),
        .serial (e1_ser)
    );

    dpod_serial u_second_start (
        .day    (second_start_day),
        .month  (second_start_month),
        .year   (second_start_year),
        .serial (s2_ser)
    );

    dpod_serial u_second_end (
        .day    (second_end_day),
        .month  (second_end_month),
        .year   (second_end_year),
        .serial (e2_ser)
    );

    // advance when the next stage is empty or draining
    always_comb
    begin
        out_load         = !out_valid_reg || !out_stall;
        stage_load       = !stage_valid_reg || out_load;
        in_stall         = !stage_load;
        stage_valid_next = stage_load ? in_valid : stage_valid_reg;
        out_valid_next   = out_load ? stage_valid_reg : out_valid_reg;
    end

    always_comb
    begin
        lo   = (s1_reg > s2_reg) ? s1_reg : s2_reg;
        hi   = (e1_reg < e2_reg) ? e1_reg : e2_reg;
        span = {1'b0, hi} - {1'b0, lo} + (SERIAL_W+1)'(1);
        if ((s1_reg > e1_reg) || (s2_reg > e2_reg) || (lo > hi))
        begin
            count_next = '0;
        end
        else if (span > (SERIAL_W+1)'(COUNT_MAX))
        begin
            count_next = COUNT_MAX;
        end
        else
        begin
            count_next = span[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load && in_valid)
        begin
            s1_reg <= s1_ser;
            e1_reg <= e1_ser;
            s2_reg <= s2_ser;
            e2_reg <= e2_ser;
        end
        if (out_load && stage_valid_reg)
        begin
            count_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign overlap_days = count_reg;

endmodule

`default_nettype wire

[dv/tb_date_period_overlap_days.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_date_period_overlap_days: self-checking bench for the period overlap block
// Feeds pairs of date periods through the valid/stall input channel, predicts
// each inclusive overlap count from day ordinals, and checks every output
// transfer in order. Runs directed corner cases, then well-formed and raw
// random periods under three flow-control mixes, draining between them.
// ============================================================================
module tb_date_period_overlap_days;
    import dpod_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int RANDOM_PER_PHASE = 660;
    localparam int MAX_REPORTS      = 10;

    localparam int unsigned DAYS_BEFORE [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    typedef struct packed {
        day_t   day;
        month_t month;
        year_t  year;
    } date_t;

    typedef struct packed {
        date_t first_start;
        date_t first_end;
        date_t second_start;
        date_t second_end;
    } period_pair_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_took   = 1'b0;
    logic         out_stall = 1'b0;
    logic         in_stall;
    logic         out_valid;
    count_t       overlap_days;
    period_pair_t drv_pair  = '0;

    period_pair_t pending_pairs [$];
    count_t       expected_overlap [$];
    count_t       want_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int mismatches     = 0;
    int transfers_in   = 0;
    int results_seen   = 0;
    int empty_overlaps = 0;
    int saturated      = 0;

    date_period_overlap_days u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .first_start_day    (drv_pair.first_start.day),
        .first_start_month  (drv_pair.first_start.month),
        .first_start_year   (drv_pair.first_start.year),
        .first_end_day      (drv_pair.first_end.day),
        .first_end_month    (drv_pair.first_end.month),
        .first_end_year     (drv_pair.first_end.year),
        .second_start_day   (drv_pair.second_start.day),
        .second_start_month (drv_pair.second_start.month),
        .second_start_year  (drv_pair.second_start.year),
        .second_end_day     (drv_pair.second_end.day),
        .second_end_month   (drv_pair.second_end.month),
        .second_end_year    (drv_pair.second_end.year),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .overlap_days       (overlap_days)
    );

    always #5 clk = ~clk;

    function automatic bit is_leap(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned date_ordinal(date_t dt);
        int unsigned y;
        int unsigned m;
        int unsigned s;
        y = dt.year;
        m = dt.month;
        if (m < 1)
            m = 1;
        if (m > 12)
            m = 12;
        s = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        s += DAYS_BEFORE[m - 1];
        if (m > 2 && is_leap(y))
            s += 1;
        return s + dt.day;
    endfunction

    function automatic count_t predict_overlap(period_pair_t p);
        int unsigned s1;
        int unsigned e1;
        int unsigned s2;
        int unsigned e2;
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        s1 = date_ordinal(p.first_start);
        e1 = date_ordinal(p.first_end);
        s2 = date_ordinal(p.second_start);
        e2 = date_ordinal(p.second_end);
        n  = 0;
        if (s1 <= e1 && s2 <= e2)
        begin
            lo = (s1 > s2) ? s1 : s2;
            hi = (e1 < e2) ? e1 : e2;
            if (lo <= hi)
                n = hi - lo + 1;
        end
        if (n > COUNT_MAX)
            n = COUNT_MAX;
        return count_t'(n);
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        case (m)
            2:              return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    function automatic date_t mk_date(int unsigned d, int unsigned m, int unsigned y);
        date_t dt;
        dt.day   = day_t'(d);
        dt.month = month_t'(m);
        dt.year  = year_t'(y);
        return dt;
    endfunction

    function automatic period_pair_t mk_pair(date_t a, date_t b, date_t c, date_t d);
        period_pair_t p;
        p.first_start  = a;
        p.first_end    = b;
        p.second_start = c;
        p.second_end   = d;
        return p;
    endfunction

    function automatic date_t calendar_date(int unsigned y);
        int unsigned m;
        m = $urandom_range(1, 12);
        return mk_date($urandom_range(1, month_days(m, y)), m, y);
    endfunction

    function automatic date_t raw_date();
        return mk_date($urandom, $urandom, $urandom);
    endfunction

    function automatic void order_dates(ref date_t a, ref date_t b);
        date_t t;
        if (date_ordinal(a) > date_ordinal(b) && $urandom_range(0, 9) != 0)
        begin
            t = a;
            a = b;
            b = t;
        end
    endfunction

    function automatic period_pair_t random_pair();
        int unsigned pick;
        int unsigned base;
        int unsigned span;
        date_t       d [4];
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            base = $urandom_range(1, 9996);
            span = $urandom_range(0, 3);
            foreach (d[i])
                d[i] = calendar_date(base + $urandom_range(0, span));
            order_dates(d[0], d[1]);
            order_dates(d[2], d[3]);
        end
        else if (pick < 85)
        begin
            foreach (d[i])
                d[i] = calendar_date($urandom_range(1, 9999));
            order_dates(d[0], d[1]);
            order_dates(d[2], d[3]);
        end
        else
        begin
            foreach (d[i])
                d[i] = raw_date();
        end
        return mk_pair(d[0], d[1], d[2], d[3]);
    endfunction

    task automatic load_directed();
        // single shared day, full valid range, disjoint, touching ends
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 2000), mk_date(1, 1, 2000),
                                        mk_date(1, 1, 2000), mk_date(1, 1, 2000)));
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 1), mk_date(31, 12, 9999),
                                        mk_date(1, 1, 1), mk_date(31, 12, 9999)));
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 2020), mk_date(10, 1, 2020),
                                        mk_date(11, 1, 2020), mk_date(20, 1, 2020)));
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 2020), mk_date(10, 1, 2020),
                                        mk_date(10, 1, 2020), mk_date(20, 1, 2020)));
        // reversed first, reversed second
        pending_pairs.push_back(mk_pair(mk_date(5, 6, 2010), mk_date(4, 6, 2010),
                                        mk_date(1, 1, 2010), mk_date(31, 12, 2010)));
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 2010), mk_date(31, 12, 2010),
                                        mk_date(1, 1, 2011), mk_date(1, 1, 2009)));
        // leap rules: 2000 leap, 1900 not, 2024 across February
        pending_pairs.push_back(mk_pair(mk_date(1, 2, 2000), mk_date(1, 3, 2000),
                                        mk_date(1, 2, 2000), mk_date(1, 3, 2000)));
        pending_pairs.push_back(mk_pair(mk_date(1, 2, 1900), mk_date(1, 3, 1900),
                                        mk_date(1, 1, 1900), mk_date(31, 12, 1900)));
        pending_pairs.push_back(mk_pair(mk_date(20, 2, 2024), mk_date(10, 3, 2024),
                                        mk_date(29, 2, 2024), mk_date(1, 4, 2024)));
        // nested and partial overlap across years
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 1990), mk_date(31, 12, 2010),
                                        mk_date(15, 7, 1999), mk_date(3, 9, 2001)));
        pending_pairs.push_back(mk_pair(mk_date(15, 7, 1999), mk_date(3, 9, 2001),
                                        mk_date(1, 1, 2000), mk_date(31, 12, 2010)));
        // month zero, months thirteen to fifteen
        pending_pairs.push_back(mk_pair(mk_date(5, 0, 2021), mk_date(5, 15, 2021),
                                        mk_date(1, 1, 2021), mk_date(31, 12, 2021)));
        pending_pairs.push_back(mk_pair(mk_date(1, 13, 2021), mk_date(31, 14, 2021),
                                        mk_date(1, 12, 2021), mk_date(31, 12, 2021)));
        // day zero and days past month end
        pending_pairs.push_back(mk_pair(mk_date(0, 3, 2023), mk_date(31, 2, 2023),
                                        mk_date(28, 2, 2023), mk_date(3, 3, 2023)));
        // year zero is a leap year
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 0), mk_date(31, 12, 0),
                                        mk_date(1, 1, 0), mk_date(31, 12, 0)));
        // saturation over the widest span, and a long overlap below the limit
        pending_pairs.push_back(mk_pair(mk_date(0, 0, 0), mk_date(31, 15, 16383),
                                        mk_date(0, 0, 0), mk_date(31, 15, 16383)));
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 0), mk_date(1, 1, 16383),
                                        mk_date(1, 1, 5000), mk_date(31, 12, 16383)));
        // all fields zero, all fields ones
        pending_pairs.push_back('0);
        pending_pairs.push_back('1);
        // year above the calendar range, reversed by month only
        pending_pairs.push_back(mk_pair(mk_date(1, 1, 12000), mk_date(1, 1, 12001),
                                        mk_date(1, 6, 12000), mk_date(1, 5, 12000)));
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || in_valid || expected_overlap.size() != 0)
            @(posedge clk);
    endtask

    // drive: advance only after a transfer, hold payload otherwise
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drv_pair <= pending_pairs.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want_count = predict_overlap(drv_pair);
                expected_overlap.push_back(want_count);
                transfers_in++;
                if (want_count == '0)
                    empty_overlaps++;
                if (want_count == COUNT_MAX)
                    saturated++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_overlap.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: overlap_days=%0d", overlap_days);
                end
                else
                begin
                    want_count = expected_overlap.pop_front();
                    if (overlap_days !== want_count)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch at result %0d: expected %0d, got %0d",
                                     results_seen, want_count, overlap_days);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct  = 15;
        recv_stall_pct = 57;
        load_directed();
        repeat (RANDOM_PER_PHASE)
            pending_pairs.push_back(random_pair());
        wait_drained();

        send_idle_pct  = 57;
        recv_stall_pct = 15;
        repeat (RANDOM_PER_PHASE)
            pending_pairs.push_back(random_pair());
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RANDOM_PER_PHASE)
            pending_pairs.push_back(random_pair());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d period pairs over three flow-control mixes; %0d results checked",
                 transfers_in, results_seen);
        $display("Empty overlaps: %0d, saturated counts: %0d, mismatches: %0d",
                 empty_overlaps, saturated, mismatches);
        if (mismatches == 0 && expected_overlap.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
